// ----- hdl/smca_pkg.sv -----
package smca_pkg;

	// list geometry
	localparam int LIST_DEPTH = 32;
	localparam int COORD_BITS = 16;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// field widths
	localparam int PORT_COORD_W = 16;
	localparam int VALUE_W      = 32;
	localparam int SUM_W        = VALUE_W + 1;
	localparam int KEY_W        = 2 * COORD_BITS;
	localparam int WORD_W       = KEY_W + VALUE_W;

	// command codes
	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	// store access from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	// one step of the merge unit
	typedef struct packed {
		logic                  take_a;
		logic                  take_b;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic [SUM_W-1:0]      sum;
		logic                  nonzero;
	} alu_res_t;

endpackage

// ----- hdl/smca_ram.sv -----
module smca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/smca_alu.sv -----
module smca_alu (
	input  logic                     a_has,
	input  logic                     b_has,
	input  logic [smca_pkg::WORD_W-1:0] a_word,
	input  logic [smca_pkg::WORD_W-1:0] b_word,
	output smca_pkg::alu_res_t       res
);
	import smca_pkg::*;

	logic [KEY_W-1:0]   key_a;
	logic [KEY_W-1:0]   key_b;
	logic [VALUE_W-1:0] val_a;
	logic [VALUE_W-1:0] val_b;
	logic [SUM_W-1:0]   op_x;
	logic [SUM_W-1:0]   op_y;
	logic [SUM_W-1:0]   sum;

	assign key_a = a_word[WORD_W-1:VALUE_W];
	assign key_b = b_word[WORD_W-1:VALUE_W];
	assign val_a = a_word[VALUE_W-1:0];
	assign val_b = b_word[VALUE_W-1:0];

	// row-major key compare picks one or both heads,
	// shared sign-extended adder, unused side contributes zero
	always_comb begin
		res.take_a  = a_has && (!b_has || (key_a <= key_b));
		res.take_b  = b_has && (!a_has || (key_b <= key_a));
		op_x        = res.take_a ? {val_a[VALUE_W-1], val_a} : '0;
		op_y        = res.take_b ? {val_b[VALUE_W-1], val_b} : '0;
		sum         = op_x + op_y;
		res.sum     = sum;
		res.nonzero = (sum != '0);
		res.row     = res.take_a ? key_a[KEY_W-1:COORD_BITS] : key_b[KEY_W-1:COORD_BITS];
		res.col     = res.take_a ? key_a[COORD_BITS-1:0] : key_b[COORD_BITS-1:0];
	end

endmodule

// ----- hdl/smca_ctrl.sv -----
module smca_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	output smca_pkg::ram_req_t           a_req,
	output smca_pkg::ram_req_t           b_req,
	output logic                         a_has,
	output logic                         b_has,
	input  smca_pkg::alu_res_t           res,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [smca_pkg::PORT_COORD_W-1:0] out_row,
	output logic [smca_pkg::PORT_COORD_W-1:0] out_col,
	output logic signed [smca_pkg::SUM_W-1:0] out_value,
	output logic                         last_entry,
	output logic                         empty_result
);
	import smca_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_CMP    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      a_cnt_q;
	logic [CNT_W-1:0]      b_cnt_q;
	logic [CNT_W-1:0]      i_q;
	logic [CNT_W-1:0]      j_q;
	logic                  pend_valid_q;
	logic [COORD_BITS-1:0] pend_row_q;
	logic [COORD_BITS-1:0] pend_col_q;
	logic [SUM_W-1:0]      pend_val_q;
	logic                  out_valid_q;

	logic in_fire;
	logic out_free;
	logic done;
	logic step_ok;
	logic a_room;
	logic b_room;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign a_room = (a_cnt_q < CNT_W'(LIST_DEPTH));
	assign b_room = (b_cnt_q < CNT_W'(LIST_DEPTH));

	// store write and read addresses
	always_comb begin
		a_req.we    = in_fire && (command == CMD_LOAD_A) && a_room;
		a_req.waddr = a_cnt_q[IDX_W-1:0];
		a_req.raddr = i_q[IDX_W-1:0];
		b_req.we    = in_fire && (command == CMD_LOAD_B) && b_room;
		b_req.waddr = b_cnt_q[IDX_W-1:0];
		b_req.raddr = j_q[IDX_W-1:0];
	end

	// merge step status
	assign a_has   = (i_q < a_cnt_q);
	assign b_has   = (j_q < b_cnt_q);
	assign done    = !a_has && !b_has;
	assign step_ok = !res.nonzero || !pend_valid_q || out_free;

	// sequencer, list counters and held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (a_req.we) begin
						a_cnt_q <= a_cnt_q + CNT_W'(1);
					end
					if (b_req.we) begin
						b_cnt_q <= b_cnt_q + CNT_W'(1);
					end
					if (in_fire && (command == CMD_START)) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (done) begin
						state_q <= ST_FINISH;
					end else if (step_ok) begin
						i_q     <= i_q + CNT_W'(res.take_a);
						j_q     <= j_q + CNT_W'(res.take_b);
						state_q <= ST_READ;
						if (res.nonzero) begin
							pend_valid_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
						a_cnt_q      <= '0;
						b_cnt_q      <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// held result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_CMP) && !done && step_ok && res.nonzero) begin
			pend_row_q <= res.row;
			pend_col_q <= res.col;
			pend_val_q <= res.sum;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((state_q == ST_CMP) && !done && step_ok && res.nonzero && pend_valid_q)
				|| ((state_q == ST_FINISH) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_CMP) && !done && step_ok && res.nonzero && pend_valid_q) begin
			out_row      <= PORT_COORD_W'(pend_row_q);
			out_col      <= PORT_COORD_W'(pend_col_q);
			out_value    <= pend_val_q;
			last_entry   <= 1'b0;
			empty_result <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			if (pend_valid_q) begin
				out_row      <= PORT_COORD_W'(pend_row_q);
				out_col      <= PORT_COORD_W'(pend_col_q);
				out_value    <= pend_val_q;
				empty_result <= 1'b0;
			end else begin
				out_row      <= '0;
				out_col      <= '0;
				out_value    <= '0;
				empty_result <= 1'b1;
			end
			last_entry <= 1'b1;
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(a_cnt_q <= CNT_W'(LIST_DEPTH)) && (b_cnt_q <= CNT_W'(LIST_DEPTH)))
		else $error("list count beyond depth");

	idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ((i_q <= a_cnt_q) && (j_q <= b_cnt_q)))
		else $error("merge index passed list count");

	empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_result) |-> (last_entry && (out_value == '0)))
		else $error("empty result not final or not zero");

	finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && out_free) |=>
		((state_q == ST_IDLE) && (a_cnt_q == '0) && (b_cnt_q == '0) && !pend_valid_q))
		else $error("lists not emptied after merge");

	idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held result left over in idle");

endmodule

// ----- hdl/sparse_matrix_coo_add_top.sv -----
// loads (commands 0 and 1) and unused codes are taken only while idle; a start takes the block busy
// merge: each step is a store read, then a compare and add; a step consumes one head of
// a list or a matching pair; a step with a nonzero sum waits while a result is held and the
// full output register is stalled; the registered store read feeds one shared compare/add unit
// a result is held until the next nonzero entry is found, the final one until the end
// reset clears the list counts, sequencer and output valid; store contents are not cleared
module sparse_matrix_coo_add_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           command,
	input  logic [smca_pkg::PORT_COORD_W-1:0]    row_index,
	input  logic [smca_pkg::PORT_COORD_W-1:0]    col_index,
	input  logic signed [smca_pkg::VALUE_W-1:0]  entry_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [smca_pkg::PORT_COORD_W-1:0]    out_row,
	output logic [smca_pkg::PORT_COORD_W-1:0]    out_col,
	output logic signed [smca_pkg::SUM_W-1:0]    out_value,
	output logic                                 last_entry,
	output logic                                 empty_result
);
	import smca_pkg::*;

	ram_req_t          a_req;
	ram_req_t          b_req;
	alu_res_t          res;
	logic              a_has;
	logic              b_has;
	logic [WORD_W-1:0] wdata;
	logic [WORD_W-1:0] a_word;
	logic [WORD_W-1:0] b_word;

	// packed store word: row, column, value
	assign wdata = {row_index[COORD_BITS-1:0], col_index[COORD_BITS-1:0], entry_value};

	smca_ram #(.WIDTH(WORD_W), .DEPTH(LIST_DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_req.we),
		.waddr (a_req.waddr),
		.wdata (wdata),
		.raddr (a_req.raddr),
		.rdata (a_word)
	);

	smca_ram #(.WIDTH(WORD_W), .DEPTH(LIST_DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_req.we),
		.waddr (b_req.waddr),
		.wdata (wdata),
		.raddr (b_req.raddr),
		.rdata (b_word)
	);

	smca_alu u_alu (
		.a_has  (a_has),
		.b_has  (b_has),
		.a_word (a_word),
		.b_word (b_word),
		.res    (res)
	);

	smca_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.a_req        (a_req),
		.b_req        (b_req),
		.a_has        (a_has),
		.b_has        (b_has),
		.res          (res),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.last_entry   (last_entry),
		.empty_result (empty_result)
	);

endmodule

// ----- verif/tb_sparse_matrix_coo_add_top.sv -----
`timescale 1ns / 1ps

module tb_sparse_matrix_coo_add_top;
	import smca_pkg::*;

	// command code that the block ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [PORT_COORD_W-1:0] COORD_MASK =
		PORT_COORD_W'((32'd1 << COORD_BITS) - 1);

	localparam int TAIL_CYCLES  = 150;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 100;

	// one expected result beat
	typedef struct packed {
		logic [PORT_COORD_W-1:0] row;
		logic [PORT_COORD_W-1:0] col;
		logic [SUM_W-1:0]        value;
		logic                    last;
		logic                    empty;
	} sum_entry_t;

	// one list entry: {row, col} key and value
	typedef struct packed {
		logic [2*PORT_COORD_W-1:0] key;
		logic [VALUE_W-1:0]        val;
	} coo_entry_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [1:0]                 command      = CMD_LOAD_A;
	logic [PORT_COORD_W-1:0]    row_index    = '0;
	logic [PORT_COORD_W-1:0]    col_index    = '0;
	logic signed [VALUE_W-1:0]  entry_value  = '0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic [PORT_COORD_W-1:0]    out_row;
	logic [PORT_COORD_W-1:0]    out_col;
	logic signed [SUM_W-1:0]    out_value;
	logic                       last_entry;
	logic                       empty_result;

	// shadow copy of the two coordinate lists
	logic [2*PORT_COORD_W-1:0] list_a_key [LIST_DEPTH];
	logic [VALUE_W-1:0]        list_a_val [LIST_DEPTH];
	logic [2*PORT_COORD_W-1:0] list_b_key [LIST_DEPTH];
	logic [VALUE_W-1:0]        list_b_val [LIST_DEPTH];
	int                        list_a_len = 0;
	int                        list_b_len = 0;

	sum_entry_t expected_sum_q [$];
	sum_entry_t merged_q [$];

	int mismatches   = 0;
	int items_sent   = 0;
	int burst_left   = 0;
	int hold_request = 0;
	int quiet_cycles = 0;

	sparse_matrix_coo_add_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.row_index    (row_index),
		.col_index    (col_index),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.last_entry   (last_entry),
		.empty_result (empty_result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: %s", $time, what);
	endtask

	// queue one merged term unless its value is zero
	function automatic void keep_nonzero(input logic [2*PORT_COORD_W-1:0] key,
		input logic [SUM_W-1:0] v);
		sum_entry_t e;
		if (v != '0) begin
			e.row   = key[2*PORT_COORD_W-1:PORT_COORD_W];
			e.col   = key[PORT_COORD_W-1:0];
			e.value = v;
			e.last  = 1'b0;
			e.empty = 1'b0;
			merged_q = {merged_q, e};
		end
	endfunction

	// merge both lists row-major, sum matching keys, then empty the lists
	function automatic void predict_sum();
		int i;
		int j;
		sum_entry_t e;
		i = 0;
		j = 0;
		merged_q.delete();
		while (i < list_a_len && j < list_b_len) begin
			if (list_a_key[i] == list_b_key[j]) begin
				keep_nonzero(list_a_key[i], {list_a_val[i][VALUE_W-1], list_a_val[i]} +
					{list_b_val[j][VALUE_W-1], list_b_val[j]});
				i++;
				j++;
			end else if (list_a_key[i] < list_b_key[j]) begin
				keep_nonzero(list_a_key[i], {list_a_val[i][VALUE_W-1], list_a_val[i]});
				i++;
			end else begin
				keep_nonzero(list_b_key[j], {list_b_val[j][VALUE_W-1], list_b_val[j]});
				j++;
			end
		end
		for (; i < list_a_len; i++)
			keep_nonzero(list_a_key[i], {list_a_val[i][VALUE_W-1], list_a_val[i]});
		for (; j < list_b_len; j++)
			keep_nonzero(list_b_key[j], {list_b_val[j][VALUE_W-1], list_b_val[j]});
		// empty sum gives a single flagged beat
		if (merged_q.size() == 0) begin
			e = '0;
			e.last  = 1'b1;
			e.empty = 1'b1;
		end else begin
			e = merged_q.pop_back();
			e.last = 1'b1;
		end
		merged_q = {merged_q, e};
		expected_sum_q = {expected_sum_q, merged_q};
		list_a_len = 0;
		list_b_len = 0;
	endfunction

	// update the shadow lists for one accepted beat
	function automatic void apply_to_lists(input logic [1:0] cmd,
		input logic [PORT_COORD_W-1:0] row, input logic [PORT_COORD_W-1:0] col,
		input logic [VALUE_W-1:0] val);
		case (cmd)
			CMD_LOAD_A: begin
				if (list_a_len < LIST_DEPTH) begin
					list_a_key[list_a_len] = {row & COORD_MASK, col & COORD_MASK};
					list_a_val[list_a_len] = val;
					list_a_len++;
				end
			end
			CMD_LOAD_B: begin
				if (list_b_len < LIST_DEPTH) begin
					list_b_key[list_b_len] = {row & COORD_MASK, col & COORD_MASK};
					list_b_val[list_b_len] = val;
					list_b_len++;
				end
			end
			CMD_START: predict_sum();
			default: ;
		endcase
	endfunction

	// drive one input beat, idling between bursts, and wait for acceptance
	task automatic send_beat(input logic [1:0] cmd, input logic [PORT_COORD_W-1:0] row,
		input logic [PORT_COORD_W-1:0] col, input logic [VALUE_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		command     <= cmd;
		row_index   <= row;
		col_index   <= col;
		entry_value <= val;
		do @(posedge clk); while (in_stall);
		apply_to_lists(cmd, row, col, val);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_sum_q.size() != 0);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	// build A and B from one rising key sequence, then load them interleaved and start
	task automatic run_round(input int n_keys, input bit wide, input bit scramble,
		input bit all_pairs);
		coo_entry_t a_list [$];
		coo_entry_t b_list [$];
		coo_entry_t tmp;
		logic [2*PORT_COORD_W-1:0] key;
		logic [2*PORT_COORD_W-1:0] step_max;
		logic [VALUE_W-1:0] v;
		int pick;
		int x;
		int y;
		step_max = wide ? 32'hFFFF_FFFF / (n_keys + 1) : 32'd3;
		key = wide ? $urandom_range(0, 255) : {14'd0, 2'($urandom()), 16'($urandom())};
		for (int k = 0; k < n_keys; k++) begin
			key  = key + $urandom_range(1, step_max);
			pick = all_pairs ? 0 : $urandom_range(0, 9);
			v    = pick_value();
			// 0..3 both lists, 4..6 A only, 7..9 B only
			if (pick <= 6)
				a_list = {a_list, coo_entry_t'({key, v})};
			if (pick <= 3)
				b_list = {b_list, coo_entry_t'({key,
					($urandom_range(0, 4) == 0) ? -v : pick_value()})};
			else if (pick >= 7)
				b_list = {b_list, coo_entry_t'({key, v})};
		end
		// out of order entries and a repeated key
		if (scramble && a_list.size() > 1) begin
			repeat (3) begin
				x = $urandom_range(0, a_list.size() - 1);
				y = $urandom_range(0, a_list.size() - 1);
				tmp = a_list[x];
				a_list[x] = a_list[y];
				a_list[y] = tmp;
			end
			a_list = {a_list, a_list[0]};
		end
		while (a_list.size() + b_list.size() > 0) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(CMD_UNUSED, $urandom(), $urandom(), $urandom());
			if (b_list.size() == 0 || (a_list.size() > 0 && $urandom_range(0, 1))) begin
				tmp = a_list.pop_front();
				send_beat(CMD_LOAD_A, tmp.key[2*PORT_COORD_W-1:PORT_COORD_W],
					tmp.key[PORT_COORD_W-1:0], tmp.val);
			end else begin
				tmp = b_list.pop_front();
				send_beat(CMD_LOAD_B, tmp.key[2*PORT_COORD_W-1:PORT_COORD_W],
					tmp.key[PORT_COORD_W-1:0], tmp.val);
			end
		end
		send_beat(CMD_START, $urandom(), $urandom(), $urandom());
	endtask

	task automatic test_empty_sum();
		send_beat(CMD_START, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	// coordinate and value extremes, widened sums at both ends
	task automatic test_field_extremes();
		send_beat(CMD_LOAD_A, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
		send_beat(CMD_LOAD_A, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
		send_beat(CMD_LOAD_B, 16'h0000, 16'h0000, 32'h7FFF_FFFF);
		send_beat(CMD_LOAD_B, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_beat(CMD_LOAD_B, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
		send_beat(CMD_START, 16'h0000, 16'h0000, 32'h0000_0000);
	endtask

	// zero from a cancelling pair, from A alone and from the tail of B
	task automatic test_zero_values();
		send_beat(CMD_LOAD_A, 16'd1, 16'd1, 5);
		send_beat(CMD_LOAD_A, 16'd2, 16'd2, 0);
		send_beat(CMD_LOAD_A, 16'd3, 16'd3, 7);
		send_beat(CMD_LOAD_B, 16'd1, 16'd1, -5);
		send_beat(CMD_LOAD_B, 16'd4, 16'd4, 0);
		send_beat(CMD_START, 16'd0, 16'd0, 0);
	endtask

	task automatic test_cancel_all();
		send_beat(CMD_LOAD_A, 16'd5, 16'd5, 9);
		send_beat(CMD_LOAD_B, 16'd5, 16'd5, -9);
		send_beat(CMD_START, 16'd0, 16'd0, 0);
	endtask

	task automatic test_unsorted_lists();
		send_beat(CMD_LOAD_A, 16'd9, 16'd9, 1);
		send_beat(CMD_LOAD_A, 16'd1, 16'd1, 2);
		send_beat(CMD_LOAD_B, 16'd5, 16'd5, 4);
		send_beat(CMD_START, 16'd0, 16'd0, 0);
	endtask

	task automatic test_unused_command();
		send_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_beat(CMD_LOAD_A, 16'd7, 16'd7, 3);
		send_beat(CMD_UNUSED, 16'h0000, 16'h0000, 32'h0000_0000);
		send_beat(CMD_START, 16'd0, 16'd0, 0);
	endtask

	// loads past the list depth on both sides
	task automatic test_full_lists();
		run_round(LIST_DEPTH + 2, 1'b1, 1'b0, 1'b1);
	endtask

	// receiver holds off across two merges, then the sender waits for all results to drain
	task automatic test_output_hold();
		hold_request = HOLD_CYCLES;
		run_round(12, 1'b1, 1'b0, 1'b0);
		run_round(10, 1'b0, 1'b0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_rounds();
		int first;
		int n;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 20);
			run_round(n, $urandom_range(0, 1), $urandom_range(0, 9) == 0, 1'b0);
		end
	endtask

	// receiver stall pattern, changing mode from phase to phase
	initial begin : receiver_pattern
		int hold_left;
		int mode;
		int phase_left;
		hold_left  = 0;
		mode       = 0;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (phase_left == 0) begin
				mode       = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					// never stall
					0: out_stall <= 1'b0;
					// stall when the phase count is a multiple of four
					1: out_stall <= (phase_left % 4 == 0);
					// coin toss
					2: out_stall <= 1'($urandom_range(0, 1));
					// mostly stalled
					default: out_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		sum_entry_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sum_q.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected: row %h col %h",
					out_row, out_col));
			end else begin
				want = expected_sum_q.pop_front();
				if (out_row !== want.row)
					report_mismatch($sformatf("out_row %h, want %h", out_row, want.row));
				if (out_col !== want.col)
					report_mismatch($sformatf("out_col %h, want %h", out_col, want.col));
				if (out_value !== want.value)
					report_mismatch($sformatf("out_value %0d, want %0d", out_value,
						$signed(want.value)));
				if (last_entry !== want.last)
					report_mismatch($sformatf("last_entry %b, want %b", last_entry, want.last));
				if (empty_result !== want.empty)
					report_mismatch($sformatf("empty_result %b, want %b", empty_result,
						want.empty));
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_sum();
		test_field_extremes();
		test_zero_values();
		test_cancel_all();
		test_unsorted_lists();
		test_unused_command();
		test_full_lists();
		test_output_hold();
		test_random_rounds();
		in_valid <= 1'b0;
		while (expected_sum_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/smca_pkg.sv
hdl/smca_ram.sv
hdl/smca_alu.sv
hdl/smca_ctrl.sv
hdl/sparse_matrix_coo_add_top.sv
verif/tb_sparse_matrix_coo_add_top.sv
